/* rtl/core/lfu_pkg.sv */
// shared types and constants for the lfu cache table
package lfu_pkg;

    localparam int unsigned MAX_ENTRIES_DEF = 16;
    localparam int unsigned KEY_W           = 32;
    localparam int unsigned DATA_W          = 32;
    localparam int unsigned COUNT_W         = 32;
    localparam int unsigned STAMP_W         = 64;
    localparam int unsigned CAP_W           = 5;

    localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hffff_ffff;
    localparam logic [DATA_W-1:0]  MISS_DATA = 32'hffff_ffff;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_TOUCH,
        UPD_WRITE,
        UPD_INSERT
    } t_upd_op;

    // partial result that travels down the row of cells
    typedef struct packed {
        logic               match;
        logic [DATA_W-1:0]  match_data;
        logic               free_found;
        logic               vict_found;
        logic [KEY_W-1:0]   vict_key;
        logic [COUNT_W-1:0] vict_count;
        logic [STAMP_W-1:0] vict_stamp;
    } t_scan_pkt;

    // entry update broadcast to all cells
    typedef struct packed {
        t_upd_op            op;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
        logic [STAMP_W-1:0] stamp;
    } t_upd;

endpackage

/* rtl/core/lfu_req_if.sv */
// request channel: command, key and write data
interface lfu_req_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic signed [lfu_pkg::KEY_W-1:0]  key;
    logic signed [lfu_pkg::DATA_W-1:0] write_value;

    modport source (output valid, command, key, write_value, input ready);
    modport sink   (input valid, command, key, write_value, output ready);
endinterface

/* rtl/core/lfu_rsp_if.sv */
// response channel: hit, read data and eviction report
interface lfu_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic signed [lfu_pkg::DATA_W-1:0] read_value;
    logic                              evicted;
    logic signed [lfu_pkg::KEY_W-1:0]  evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

/* rtl/core/lfu_cache_table_core.sv */
// lfu cache table: row of entry cells with scan and update control
//
//   channel   dir  handshake        payload
//   i_req     in   valid/ready      command, key, write_value
//   o_rsp     out  valid/ready      hit, read_value, evicted, evicted_key
//   i_cfg     in   write enable     capacity (5 bits)
//
// a request is accepted, then the scan packet walks the row of MAX_ENTRIES
// cells one cell per cycle, and a decide step updates the chosen cell and
// loads the response register. reset is synchronous and clears valid bits,
// counters and control; entry payload is left as is. a response held by
// o_rsp.ready blocks only the decide step, so the next request may be
// accepted meanwhile but waits there
module lfu_cache_table_core #(
    parameter int unsigned MAX_ENTRIES = lfu_pkg::MAX_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lfu_req_if.sink                      i_req,
    lfu_rsp_if.source                    o_rsp,
    input  logic                         i_cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]    i_cfg_wdata
);

    localparam int unsigned IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned USED_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CMP_W  = (USED_W > lfu_pkg::CAP_W) ? USED_W : lfu_pkg::CAP_W;

    // control and request registers
    lfu_pkg::t_state                 r_state, n_state;
    logic [IDX_W-1:0]                r_cnt;
    logic                            r_cmd;
    logic [lfu_pkg::KEY_W-1:0]       r_key;
    logic [lfu_pkg::DATA_W-1:0]      r_wv;
    logic [lfu_pkg::STAMP_W-1:0]     r_now;
    logic [lfu_pkg::STAMP_W-1:0]     r_clock;
    logic [USED_W-1:0]               r_used;
    logic [lfu_pkg::CAP_W-1:0]       r_capacity;

    // response register
    logic                            r_out_valid;
    logic                            r_out_hit;
    logic [lfu_pkg::DATA_W-1:0]      r_out_rd;
    logic                            r_out_ev;
    logic [lfu_pkg::KEY_W-1:0]       r_out_evk;

    // scan chain
    lfu_pkg::t_scan_pkt              pkt       [MAX_ENTRIES+1];
    logic [IDX_W-1:0]                match_idx [MAX_ENTRIES+1];
    logic [IDX_W-1:0]                free_idx  [MAX_ENTRIES+1];
    logic [IDX_W-1:0]                vict_idx  [MAX_ENTRIES+1];
    lfu_pkg::t_scan_pkt              last;

    // decision
    logic                            req_fire;
    logic                            scan_end;
    logic                            load;
    logic                            room;
    logic                            d_hit;
    logic [lfu_pkg::DATA_W-1:0]      d_rd;
    logic                            d_ev;
    logic [lfu_pkg::KEY_W-1:0]       d_evk;
    logic                            d_used_inc;
    lfu_pkg::t_upd_op                d_op;
    logic [IDX_W-1:0]                d_slot;
    lfu_pkg::t_upd                   upd;

    assign req_fire = i_req.valid && i_req.ready;
    assign scan_end = (r_cnt == IDX_W'(MAX_ENTRIES - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfu_pkg::S_IDLE: if (req_fire) n_state = lfu_pkg::S_SCAN;
            lfu_pkg::S_SCAN: if (scan_end) n_state = lfu_pkg::S_DONE;
            lfu_pkg::S_DONE: if (load)     n_state = lfu_pkg::S_IDLE;
            default:                       n_state = lfu_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_req.ready = 1'b0;
        load        = 1'b0;
        unique case (r_state)
            lfu_pkg::S_IDLE: i_req.ready = 1'b1;
            lfu_pkg::S_SCAN: begin
            end
            lfu_pkg::S_DONE: load = !r_out_valid || o_rsp.ready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // scan cycle counter, restarted with each request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (req_fire) begin
            r_cnt <= '0;
        end else if (r_state == lfu_pkg::S_SCAN) begin
            r_cnt <= r_cnt + IDX_W'(1);
        end
    end

    // latch the request and stamp it with the access clock
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_cmd <= i_req.command;
            r_key <= i_req.key;
            r_wv  <= i_req.write_value;
            r_now <= r_clock;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock <= '0;
        end else if (req_fire) begin
            r_clock <= r_clock + 64'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lfu_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // row of cells; the packet enters empty at cell 0
    assign pkt[0]       = '0;
    assign match_idx[0] = '0;
    assign free_idx[0]  = '0;
    assign vict_idx[0]  = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        lfu_cell #(
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_idx       (IDX_W'(g)),
            .i_key       (r_key),
            .i_pkt       (pkt[g]),
            .i_match_idx (match_idx[g]),
            .i_free_idx  (free_idx[g]),
            .i_vict_idx  (vict_idx[g]),
            .o_pkt       (pkt[g+1]),
            .o_match_idx (match_idx[g+1]),
            .o_free_idx  (free_idx[g+1]),
            .o_vict_idx  (vict_idx[g+1]),
            .i_upd       (upd),
            .i_upd_slot  (d_slot)
        );
    end

    assign last = pkt[MAX_ENTRIES];

    // room for an insert without eviction: used below min(capacity, size)
    assign room = (CMP_W'(r_used) < CMP_W'(r_capacity)) &&
                  (CMP_W'(r_used) < CMP_W'(MAX_ENTRIES));

    // decide what the finished scan means
    always_comb begin
        d_hit      = 1'b0;
        d_rd       = '0;
        d_ev       = 1'b0;
        d_evk      = '0;
        d_used_inc = 1'b0;
        d_op       = lfu_pkg::UPD_NONE;
        d_slot     = '0;
        if (r_cmd == lfu_pkg::CMD_GET) begin
            if (last.match) begin
                d_hit  = 1'b1;
                d_rd   = last.match_data;
                d_op   = lfu_pkg::UPD_TOUCH;
                d_slot = match_idx[MAX_ENTRIES];
            end else begin
                d_rd = lfu_pkg::MISS_DATA;
            end
        end else if (r_capacity != '0) begin
            if (last.match) begin
                d_hit  = 1'b1;
                d_op   = lfu_pkg::UPD_WRITE;
                d_slot = match_idx[MAX_ENTRIES];
            end else if (room) begin
                d_op       = lfu_pkg::UPD_INSERT;
                d_slot     = free_idx[MAX_ENTRIES];
                d_used_inc = 1'b1;
            end else begin
                // full: replace the least used, oldest entry
                d_op   = lfu_pkg::UPD_INSERT;
                d_slot = vict_idx[MAX_ENTRIES];
                d_ev   = last.vict_found;
                d_evk  = last.vict_found ? last.vict_key : '0;
            end
        end
    end

    // update goes out only in the cycle the response is loaded
    always_comb begin
        upd.op    = load ? d_op : lfu_pkg::UPD_NONE;
        upd.key   = r_key;
        upd.data  = r_wv;
        upd.stamp = r_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (load && d_used_inc) begin
            r_used <= r_used + USED_W'(1);
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_hit <= d_hit;
            r_out_rd  <= d_rd;
            r_out_ev  <= d_ev;
            r_out_evk <= d_evk;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.read_value  = r_out_rd;
    assign o_rsp.evicted     = r_out_ev;
    assign o_rsp.evicted_key = r_out_evk;

endmodule

/* rtl/core/lfu_cell.sv */
// one cache entry with its stage of the lookup and victim scan
module lfu_cell #(
    parameter int unsigned IDX_W = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [IDX_W-1:0]                  i_idx,
    input  logic [lfu_pkg::KEY_W-1:0]         i_key,
    input  lfu_pkg::t_scan_pkt                i_pkt,
    input  logic [IDX_W-1:0]                  i_match_idx,
    input  logic [IDX_W-1:0]                  i_free_idx,
    input  logic [IDX_W-1:0]                  i_vict_idx,
    output lfu_pkg::t_scan_pkt                o_pkt,
    output logic [IDX_W-1:0]                  o_match_idx,
    output logic [IDX_W-1:0]                  o_free_idx,
    output logic [IDX_W-1:0]                  o_vict_idx,
    input  lfu_pkg::t_upd                     i_upd,
    input  logic [IDX_W-1:0]                  i_upd_slot
);

    logic                              r_valid;
    logic [lfu_pkg::KEY_W-1:0]         r_key;
    logic [lfu_pkg::DATA_W-1:0]        r_data;
    logic [lfu_pkg::COUNT_W-1:0]       r_count;
    logic [lfu_pkg::STAMP_W-1:0]       r_stamp;

    lfu_pkg::t_scan_pkt                r_pkt;
    lfu_pkg::t_scan_pkt                n_pkt;
    logic [IDX_W-1:0]                  r_match_idx, n_match_idx;
    logic [IDX_W-1:0]                  r_free_idx, n_free_idx;
    logic [IDX_W-1:0]                  r_vict_idx, n_vict_idx;
    logic                              sel;
    logic [lfu_pkg::COUNT_W-1:0]       count_inc;

    // scan stage: earlier cells win on match, free slot and victim ties
    always_comb begin
        n_pkt       = i_pkt;
        n_match_idx = i_match_idx;
        n_free_idx  = i_free_idx;
        n_vict_idx  = i_vict_idx;
        if (!i_pkt.match && r_valid && (r_key == i_key)) begin
            n_pkt.match      = 1'b1;
            n_pkt.match_data = r_data;
            n_match_idx      = i_idx;
        end
        if (!i_pkt.free_found && !r_valid) begin
            n_pkt.free_found = 1'b1;
            n_free_idx       = i_idx;
        end
        if (r_valid && (!i_pkt.vict_found || (r_count < i_pkt.vict_count) ||
                        ((r_count == i_pkt.vict_count) &&
                         (r_stamp < i_pkt.vict_stamp)))) begin
            n_pkt.vict_found = 1'b1;
            n_pkt.vict_key   = r_key;
            n_pkt.vict_count = r_count;
            n_pkt.vict_stamp = r_stamp;
            n_vict_idx       = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pkt       <= n_pkt;
        r_match_idx <= n_match_idx;
        r_free_idx  <= n_free_idx;
        r_vict_idx  <= n_vict_idx;
    end

    assign o_pkt       = r_pkt;
    assign o_match_idx = r_match_idx;
    assign o_free_idx  = r_free_idx;
    assign o_vict_idx  = r_vict_idx;

    // entry update
    assign sel       = (i_upd.op != lfu_pkg::UPD_NONE) && (i_upd_slot == i_idx);
    assign count_inc = (r_count == lfu_pkg::COUNT_MAX) ? r_count
                                                       : r_count + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (sel && (i_upd.op == lfu_pkg::UPD_INSERT)) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel) begin
            unique case (i_upd.op)
                lfu_pkg::UPD_TOUCH: begin
                    r_count <= count_inc;
                    r_stamp <= i_upd.stamp;
                end
                lfu_pkg::UPD_WRITE: begin
                    r_data  <= i_upd.data;
                    r_count <= count_inc;
                    r_stamp <= i_upd.stamp;
                end
                lfu_pkg::UPD_INSERT: begin
                    r_key   <= i_upd.key;
                    r_data  <= i_upd.data;
                    r_count <= '0;
                    r_stamp <= i_upd.stamp;
                end
                lfu_pkg::UPD_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

endmodule
